/* design/qpt_pkg.sv */
// Shared types, codes and the quadrature step table for the position tracker.
// No dependencies; every other design file imports this package.
package qpt_pkg;

  localparam int unsigned PositionWidthDefault = 32;
  localparam int unsigned TicksWidth = 20;
  localparam int unsigned OutPosWidth = 32;
  localparam int unsigned TickCountWidth = 32;

  localparam logic [TicksWidth-1:0] TicksPerRevReset = TicksWidth'(4096);

  // Event kinds carried in s_axis_tuser.
  localparam logic [1:0] CmdEdge  = 2'd0;
  localparam logic [1:0] CmdIndex = 2'd1;
  localparam logic [1:0] CmdQuad  = 2'd2;

  // Configuration register indexes.
  localparam logic CfgTicksPerRev = 1'b0;
  localparam logic CfgIndexMode   = 1'b1;

  localparam logic signed [1:0] DirBack = -2'sd1;
  localparam logic signed [1:0] DirNone = 2'sd0;
  localparam logic signed [1:0] DirFwd  = 2'sd1;

  typedef struct packed {
    logic [TicksWidth-1:0] rev_counts;
    logic                  index_mode;
  } cfg_t;

  // Step for the transition {previous pins, current pins}.
  function automatic logic signed [1:0] step_lookup(input logic [3:0] idx);
    logic signed [1:0] dir;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: dir = DirBack;
      4'd2, 4'd4, 4'd11, 4'd13: dir = DirFwd;
      default: dir = DirNone;
    endcase
    return dir;
  endfunction

endpackage

/* design/qpt_update.sv */
// Next-state logic of the position tracker: one event applied to the held state.
// Depends on qpt_pkg for the event codes, the configuration struct and the step table.
module qpt_update #(
  parameter int unsigned POSITION_WIDTH = qpt_pkg::PositionWidthDefault
) (
  input  logic [1:0]                       cmd_i,
  input  logic [1:0]                       pins_i,
  input  qpt_pkg::cfg_t                    cfg_i,
  input  logic [1:0]                       prev_pins_i,
  input  logic [POSITION_WIDTH-1:0]        pos_i,
  input  logic signed [1:0]                dir_i,
  input  logic [qpt_pkg::TickCountWidth-1:0] ticks_i,
  output logic [1:0]                       prev_pins_o,
  output logic [POSITION_WIDTH-1:0]        pos_o,
  output logic signed [1:0]                dir_o,
  output logic [qpt_pkg::TickCountWidth-1:0] ticks_o
);
  import qpt_pkg::*;

  localparam int unsigned CmpWidth = (POSITION_WIDTH > TicksWidth) ? POSITION_WIDTH : TicksWidth;
  localparam logic [POSITION_WIDTH-1:0] PosOne = POSITION_WIDTH'(1);

  // A negative position is never above the bound.
  function automatic logic above_bound(input logic [POSITION_WIDTH-1:0] p,
                                       input logic [TicksWidth-1:0] bound);
    return !p[POSITION_WIDTH-1] && (CmpWidth'(p) > CmpWidth'(bound));
  endfunction

  logic [POSITION_WIDTH-1:0] pos_inc;
  logic [POSITION_WIDTH-1:0] pos_dec;
  logic [POSITION_WIDTH-1:0] pos_step;
  logic signed [1:0]         quad_dir;

  assign pos_inc  = pos_i + PosOne;
  assign pos_dec  = pos_i - PosOne;
  assign quad_dir = step_lookup({prev_pins_i, pins_i});

  always_comb begin
    if (quad_dir == DirFwd) begin
      pos_step = pos_inc;
    end else if (quad_dir == DirBack) begin
      pos_step = pos_dec;
    end else begin
      pos_step = pos_i;
    end
  end

  always_comb begin
    prev_pins_o = prev_pins_i;
    pos_o       = pos_i;
    dir_o       = dir_i;
    ticks_o     = ticks_i;
    unique case (cmd_i)
      CmdEdge: begin
        pos_o = above_bound(pos_inc, cfg_i.rev_counts) ? PosOne : pos_inc;
      end
      CmdIndex: begin
        pos_o   = PosOne;
        ticks_o = ticks_i + 1'b1;
      end
      CmdQuad: begin
        prev_pins_o = pins_i;
        dir_o       = quad_dir;
        pos_o       = pos_step;
        if (!cfg_i.index_mode) begin
          if (pos_step == '0) begin
            pos_o = POSITION_WIDTH'(cfg_i.rev_counts);
          end else if (above_bound(pos_step, cfg_i.rev_counts)) begin
            pos_o = PosOne;
          end
          ticks_o = ticks_i + 1'b1;
        end
      end
      default: begin
        // The unused code leaves the state as it is.
      end
    endcase
  end

endmodule

/* design/quadrature_position_tracker.sv */
// Top level of the spindle position tracker: input stage, state, result register.
// Depends on qpt_pkg and instantiates qpt_update.
//
//   Channel   Direction  tdata                                   tuser
//   s_axis    in         [1:0] quad_pins                         [1:0] cmd
//   m_axis    out        [31:0] position, [33:32] direction,     none
//                        [65:34] tick_count
//   cfg       in         write enable, index, 20-bit data        none
//
// One item per cycle is sustained unless the result stalls; a stalled result holds in the
// result register while the input stage keeps one more item. Each item passes the input
// stage, then the result register. The rate is set by the state update, one add and two
// compares between the two. Reset clears the state and loads the register defaults.
module quadrature_position_tracker #(
  parameter int unsigned POSITION_WIDTH = qpt_pkg::PositionWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [1:0] quad_pins
  input  logic [1:0]                      s_axis_tuser,  // [1:0] cmd
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [71:0]                     m_axis_tdata,  // position, direction, tick_count
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [qpt_pkg::TicksWidth-1:0]  cfg_data_i
);
  import qpt_pkg::*;

  cfg_t cfg_q;

  logic       in_valid_q;
  logic [1:0] in_cmd_q;
  logic [1:0] in_pins_q;
  logic       advance;

  logic [1:0]                prev_pins_q, prev_pins_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic signed [1:0]         dir_q, dir_d;
  logic [TickCountWidth-1:0] ticks_q, ticks_d;

  logic                      out_valid_q;
  logic [OutPosWidth-1:0]    out_pos_q, out_pos_d;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rev_counts <= TicksPerRevReset;
      cfg_q.index_mode <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgTicksPerRev: cfg_q.rev_counts <= cfg_data_i;
        CfgIndexMode:   cfg_q.index_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q  <= s_axis_tuser;
      in_pins_q <= s_axis_tdata[1:0];
    end
  end

  qpt_update #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_update (
    .cmd_i       (in_cmd_q),
    .pins_i      (in_pins_q),
    .cfg_i       (cfg_q),
    .prev_pins_i (prev_pins_q),
    .pos_i       (pos_q),
    .dir_i       (dir_q),
    .ticks_i     (ticks_q),
    .prev_pins_o (prev_pins_d),
    .pos_o       (pos_d),
    .dir_o       (dir_d),
    .ticks_o     (ticks_d)
  );

  // The reported position is the register sign-extended or cut to 32 bits.
  if (POSITION_WIDTH >= OutPosWidth) begin : g_pos_cut
    assign out_pos_d = pos_d[OutPosWidth-1:0];
  end else begin : g_pos_ext
    assign out_pos_d = {{(OutPosWidth-POSITION_WIDTH){pos_d[POSITION_WIDTH-1]}}, pos_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pins_q <= '0;
      pos_q       <= '0;
      dir_q       <= DirNone;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      prev_pins_q <= prev_pins_d;
      pos_q       <= pos_d;
      dir_q       <= dir_d;
      ticks_q     <= ticks_d;
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pos_q <= out_pos_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, ticks_q, dir_q, out_pos_q};

endmodule
